### design/gb3_pkg.sv
// Shared types, constants and helpers for the 3x3 binomial blur.
package gb3_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 12;
    localparam int POS_W          = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int ROW_SUM_W      = PIX_W + 2;
    localparam int SUM_W          = PIX_W + 4;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] t_pix;
    // one window column: [0] two rows up, [1] previous row, [2] current row
    typedef t_pix [2:0] t_col;

    // tap selection for one result
    typedef struct packed {
        logic bot_row;   // result lies on the current (bottom) row
        logic right_col; // result lies on the current column
        logic c_is0;
        logic c_is1;
        logic r_is0;
        logic r_is1;
    } t_tap_sel;

    // last valid index of a dimension: zero acts as one, above the limit clips
    function automatic int unsigned dim_last(input int unsigned v, input int unsigned lim);
        int unsigned res;
        if (v == 0) begin
            res = 0;
        end else if (v > lim) begin
            res = lim - 1;
        end else begin
            res = v - 1;
        end
        return res;
    endfunction

endpackage

### design/gb3_line_buf.sv
// Two-line pixel store: one read-modify-write per pixel with write-to-read bypass.
module gb3_line_buf import gb3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_pix          i_wr_pix,
    output t_pix          o_line_b,
    output t_pix          o_line_a
);

    // upper half: two rows up, lower half: previous row
    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [2*PIX_W-1:0] r_byp;
    logic               r_byp_hit;
    logic [2*PIX_W-1:0] cur;
    logic [2*PIX_W-1:0] wr_data;

    assign cur      = r_byp_hit ? r_byp : r_rd;
    assign o_line_b = cur[2*PIX_W-1:PIX_W];
    assign o_line_a = cur[PIX_W-1:0];
    // previous row moves up, new pixel becomes previous row
    assign wr_data  = {cur[PIX_W-1:0], i_wr_pix};

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // same address written and read at one edge: take the new word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_byp_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp <= wr_data;
        end
    end

endmodule

### design/gb3_col_cell.sv
// One window column cell: holds three pixels and passes them to its neighbor on shift.
module gb3_col_cell import gb3_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_shift,
    input  t_col i_col,
    output t_col o_col
);

    t_col r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

### design/gb3_kernel.sv
// Weighted 3x3 sum with edge replication and round-half-even divide by 16.
module gb3_kernel import gb3_pkg::*; (
    input  t_col [2:0] i_win,
    input  t_tap_sel   i_sel,
    output t_pix       o_pix
);

    logic [1:0]           sel_l;
    logic [1:0]           sel_c;
    logic [1:0]           sel_t;
    logic [1:0]           sel_m;
    t_col                 col_l;
    t_col                 col_c;
    t_col                 col_r;
    logic [ROW_SUM_W-1:0] sum_t;
    logic [ROW_SUM_W-1:0] sum_m;
    logic [ROW_SUM_W-1:0] sum_b;
    logic [SUM_W-1:0]     total;
    t_pix                 quo;
    logic [3:0]           rem;
    logic                 inc;

    function automatic logic [ROW_SUM_W-1:0] row_sum(input t_col l, input t_col c,
                                                     input t_col r, input logic [1:0] i);
        return {2'b00, l[i]} + {1'b0, c[i], 1'b0} + {2'b00, r[i]};
    endfunction

    // replicate the edge column or row where the window runs past the image
    always_comb begin
        if (i_sel.right_col) begin
            sel_l = i_sel.c_is0 ? 2'd2 : 2'd1;
            sel_c = 2'd2;
        end else begin
            sel_l = i_sel.c_is1 ? 2'd1 : 2'd0;
            sel_c = 2'd1;
        end
        if (i_sel.bot_row) begin
            sel_t = i_sel.r_is0 ? 2'd2 : 2'd1;
            sel_m = 2'd2;
        end else begin
            sel_t = i_sel.r_is1 ? 2'd1 : 2'd0;
            sel_m = 2'd1;
        end
    end

    assign col_l = i_win[sel_l];
    assign col_c = i_win[sel_c];
    assign col_r = i_win[2];

    assign sum_t = row_sum(col_l, col_c, col_r, sel_t);
    assign sum_m = row_sum(col_l, col_c, col_r, sel_m);
    assign sum_b = row_sum(col_l, col_c, col_r, 2'd2);
    assign total = {2'b00, sum_t} + {1'b0, sum_m, 1'b0} + {2'b00, sum_b};

    assign quo   = total[SUM_W-1:4];
    assign rem   = total[3:0];
    assign inc   = (rem > 4'd8) || ((rem == 4'd8) && quo[0]);
    assign o_pix = quo + t_pix'(inc);

endmodule

### design/gaussian_blur_3x3.sv
// A result passes through stage 1, the window stage and the result register before it appears.
// Throughput: one pixel per cycle while each pixel yields at most one result and the output
// is not stalled; a pixel with more results holds the input while the single kernel drains
// them: two at the last pixel of a row and at bottom-row pixels past the first column, four at
// the frame's last. Reset clears the pipeline, the window and the position counters and loads
// 640 x 480; the line memory is not cleared.
module gaussian_blur_3x3 import gb3_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_pixel_out,
    output logic [POS_W-1:0]     o_out_row,
    output logic [POS_W-1:0]     o_out_col,
    output logic                 o_frame_end,
    output logic                 o_run_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [CW-1:0] WLastReset = CW'(dim_last(WIDTH_RESET, MAX_WIDTH));
    localparam logic [RW-1:0] HLastReset = RW'(dim_last(HEIGHT_RESET, MAX_HEIGHT));

    typedef struct packed {
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        logic          c_is0;
        logic          c_is1;
        logic          r_is0;
        logic          r_is1;
    } t_item;

    // geometry and position
    logic [CW-1:0] r_w_last, n_w_last;
    logic [RW-1:0] r_h_last, n_h_last;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;

    // stage 1: pixel waiting for its line-memory read
    logic          r_s1_v, n_s1_v;
    t_item         r_s1_item;
    logic [3:0]    r_s1_mask;
    t_pix          r_s1_pix;

    // stage 2: window loaded, results pending in mask
    // mask bits: row above at c-1, row above at c, this row at c-1, this row at c
    t_item         r_s2_item;
    logic [3:0]    r_s2_mask, n_s2_mask;

    // result register
    logic          r_out_v, n_out_v;
    t_pix          r_out_pix;
    logic [POS_W-1:0] r_out_row;
    logic [POS_W-1:0] r_out_col;
    logic          r_out_fe;
    logic          r_out_last;

    logic          in_acc;
    logic          out_free;
    logic          emit;
    logic          s2_take;
    logic          s1_adv;
    logic [3:0]    pick;
    logic [3:0]    rest;
    logic          lastc;
    logic          bot;
    t_item         acc_item;
    logic [3:0]    acc_mask;
    t_tap_sel      tap_sel;
    t_pix          blur_pix;
    t_pix          line_b;
    t_pix          line_a;
    t_col [3:0]    chain;
    logic [CW-1:0] emit_col;
    logic [RW-1:0] emit_row;

    // pending results go out lowest bit first, which is raster order
    assign pick     = r_s2_mask & (~r_s2_mask + 4'd1);
    assign rest     = r_s2_mask & ~pick;
    assign out_free = !r_out_v || i_out_ready;
    assign emit     = (r_s2_mask != 4'd0) && out_free;
    assign s2_take  = (rest == 4'd0) && ((r_s2_mask == 4'd0) || out_free);
    assign s1_adv   = r_s1_v && s2_take;
    assign o_in_ready = !r_s1_v || s2_take;
    assign in_acc   = i_in_valid && o_in_ready;

    assign lastc = (r_col == r_w_last);
    assign bot   = (r_row == r_h_last);

    always_comb begin
        acc_item.col   = r_col;
        acc_item.row   = r_row;
        acc_item.c_is0 = (r_col == '0);
        acc_item.c_is1 = (r_col == CW'(1));
        acc_item.r_is0 = (r_row == '0);
        acc_item.r_is1 = (r_row == RW'(1));
        acc_mask[0]    = !acc_item.r_is0 && !acc_item.c_is0;
        acc_mask[1]    = !acc_item.r_is0 && lastc;
        acc_mask[2]    = bot && !acc_item.c_is0;
        acc_mask[3]    = bot && lastc;
    end

    gb3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_item.col),
        .i_wr_pix  (r_s1_pix),
        .o_line_b  (line_b),
        .o_line_a  (line_a)
    );

    // newest column enters at the right end of the chain
    assign chain[3] = {r_s1_pix, line_a, line_b};

    for (genvar g = 0; g < 3; g++) begin : g_cells
        gb3_col_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_adv),
            .i_col   (chain[g+1]),
            .o_col   (chain[g])
        );
    end

    always_comb begin
        tap_sel.bot_row   = pick[2] || pick[3];
        tap_sel.right_col = pick[1] || pick[3];
        tap_sel.c_is0     = r_s2_item.c_is0;
        tap_sel.c_is1     = r_s2_item.c_is1;
        tap_sel.r_is0     = r_s2_item.r_is0;
        tap_sel.r_is1     = r_s2_item.r_is1;
    end

    gb3_kernel u_kernel (
        .i_win (chain[2:0]),
        .i_sel (tap_sel),
        .o_pix (blur_pix)
    );

    assign emit_col = tap_sel.right_col ? r_s2_item.col : r_s2_item.col - CW'(1);
    assign emit_row = tap_sel.bot_row ? r_s2_item.row : r_s2_item.row - RW'(1);

    always_comb begin
        n_w_last  = r_w_last;
        n_h_last  = r_h_last;
        n_col     = r_col;
        n_row     = r_row;
        n_s1_v    = r_s1_v;
        n_s2_mask = r_s2_mask;
        n_out_v   = r_out_v;

        if (in_acc) begin
            if (lastc) begin
                n_col = '0;
                n_row = bot ? '0 : r_row + RW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end

        // either register write restarts the frame
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IDX_WIDTH:  n_w_last = CW'(dim_last(32'(i_cfg_wdata), MAX_WIDTH));
                CFG_IDX_HEIGHT: n_h_last = RW'(dim_last(32'(i_cfg_wdata), MAX_HEIGHT));
                default: ;
            endcase
            n_col = '0;
            n_row = '0;
        end

        if (in_acc) begin
            n_s1_v = 1'b1;
        end else if (s1_adv) begin
            n_s1_v = 1'b0;
        end

        if (s1_adv) begin
            n_s2_mask = r_s1_mask;
        end else if (s2_take) begin
            n_s2_mask = 4'd0;
        end else if (emit) begin
            n_s2_mask = rest;
        end

        if (emit) begin
            n_out_v = 1'b1;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last  <= WLastReset;
            r_h_last  <= HLastReset;
            r_col     <= '0;
            r_row     <= '0;
            r_s1_v    <= 1'b0;
            r_s2_mask <= 4'd0;
            r_out_v   <= 1'b0;
        end else begin
            r_w_last  <= n_w_last;
            r_h_last  <= n_h_last;
            r_col     <= n_col;
            r_row     <= n_row;
            r_s1_v    <= n_s1_v;
            r_s2_mask <= n_s2_mask;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item <= acc_item;
            r_s1_mask <= acc_mask;
            r_s1_pix  <= i_pixel_in;
        end
        if (s1_adv) begin
            r_s2_item <= r_s1_item;
        end
        if (emit) begin
            r_out_pix  <= blur_pix;
            r_out_row  <= POS_W'(emit_row);
            r_out_col  <= POS_W'(emit_col);
            r_out_fe   <= pick[3];
            r_out_last <= (rest == 4'd0);
        end
    end

    assign o_out_valid = r_out_v;
    assign o_pixel_out = r_out_pix;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_frame_end = r_out_fe;
    assign o_run_last  = r_out_last;

    // the bottom-right result is always the last one of its pixel
    a_fe_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_run_last)
        else $error("frame end without run end");

    // pending results hold while the result register is blocked
    a_mask_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_mask != 4'd0) && !out_free |=> $stable(r_s2_mask))
        else $error("pending results changed during output stall");

    // sending the final result with nothing behind it empties the window stage
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (rest == 4'd0) && !r_s1_v |=> (r_s2_mask == 4'd0))
        else $error("window stage not drained after final result");

endmodule
